// ===== sv/bkc_pkg.sv =====
// Shared types, constants and saturation helpers of the Bezier keyframe curve sampler.
package bkc_pkg;

  localparam int MAX_KEYS_DEF = 16;
  localparam int MAX_ITER_DEF = 20;

  localparam logic [1:0] REG_KEY_COUNT   = 2'd0;
  localparam logic [1:0] REG_FRAME_COUNT = 2'd1;
  localparam logic [1:0] REG_BLEND       = 2'd2;

  localparam int MA_W  = 20;
  localparam int MB_W  = 42;
  localparam int MP_W  = MA_W + MB_W;
  localparam int ACC_W = 50;

  localparam logic [16:0] STEP_START = 17'd65470;
  localparam logic signed [42:0] TOLERANCE = 43'sd655;
  localparam logic [16:0] ONE_Q = 17'd65536;

  typedef struct packed {
    logic        [15:0] frame;
    logic signed [31:0] value;
    logic               hold;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
  } key_t;

  function automatic logic signed [MB_W-1:0] sat_x(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = (ACC_W'(1) <<< 40) - ACC_W'(1);
    lo = -(ACC_W'(1) <<< 40);
    if (v > hi) begin
      sat_x = MB_W'(hi);
    end else if (v < lo) begin
      sat_x = MB_W'(lo);
    end else begin
      sat_x = MB_W'(v);
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(64'sh7FFFFFFF)) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -ACC_W'(64'sh80000000)) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ===== sv/bkc_table.sv =====
// Keyframe table memory with one write port and one registered read port.
module bkc_table
  import bkc_pkg::*;
#(
  parameter int MAX_KEYS = MAX_KEYS_DEF,
  parameter int AW = $clog2(MAX_KEYS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  key_t          wdata,
  input  logic [AW-1:0] raddr,
  output key_t          rdata_r
);

  key_t mem [MAX_KEYS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== sv/bkc_mul.sv =====
// Shared signed multiplier with a registered product.
module bkc_mul
  import bkc_pkg::*;
(
  input  logic                    clk,
  input  logic signed [MA_W-1:0]  a,
  input  logic signed [MB_W-1:0]  b,
  output logic signed [MP_W-1:0]  p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

// ===== sv/bezier_keyframe_curve_sampler.sv =====
// Top level of the Bezier keyframe curve sampler: sequencer around a shared multiplier.
// Usage: a word is accepted when start is high and busy is low. A load word
// (in_mode 0) writes one key into the table at that edge and leaves busy low.
// A sample word (in_mode 1) on a non-empty curve raises busy until its single result is shown on
// out_sample_value and out_curve_empty for one cycle, marked by out_valid.
// The config port (cfg_we, cfg_index, cfg_wdata) writes one of key_count, frame_count
// and blend_enable per write, chosen by cfg_index; write it only while busy is low.
// A sample word scans the keys, then for a curved segment runs three steps of
// segment setup, up to MAX_ITERATIONS bisection passes and one pass of the value
// curve, all through the one multiplier; with blending this runs twice and
// three mixing steps follow. An empty curve answers without raising busy.
// Reset clears the sequencer and the config registers; the key table is not
// cleared, so slots in use must be loaded before sampling.
// The receiver takes every result when shown and cannot stall the block.
module bezier_keyframe_curve_sampler
  import bkc_pkg::*;
#(
  parameter int MAX_KEYS = MAX_KEYS_DEF,
  parameter int MAX_ITERATIONS = MAX_ITER_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_mode,
  input  logic [3:0]         in_key_slot,
  input  logic [15:0]        in_key_frame,
  input  logic signed [31:0] in_key_value,
  input  logic               in_key_hold,
  input  logic signed [31:0] in_out_handle_x,
  input  logic signed [31:0] in_out_handle_y,
  input  logic signed [31:0] in_in_handle_x,
  input  logic signed [31:0] in_in_handle_y,
  input  logic [31:0]        in_sample_position,
  output logic               out_valid,
  output logic signed [31:0] out_sample_value,
  output logic               out_curve_empty,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  localparam int AW = $clog2(MAX_KEYS);
  localparam int NW = $clog2(MAX_KEYS + 1);
  localparam int IW = $clog2(MAX_ITERATIONS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_X1   = 4'd3;
  localparam logic [3:0] S_X2   = 4'd4;
  localparam logic [3:0] S_X3   = 4'd5;
  localparam logic [3:0] S_BZ   = 4'd6;
  localparam logic [3:0] S_YST  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_MIX1 = 4'd9;
  localparam logic [3:0] S_MIX2 = 4'd10;
  localparam logic [3:0] S_MIX3 = 4'd11;

  logic [3:0] state_r, state_nxt;

  logic [4:0]  key_count_r;
  logic [15:0] frame_count_r;
  logic        blend_cfg_r;

  logic [AW-1:0] idx_r, idx_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [15:0]   f_r, f_nxt;
  logic [15:0]   second_r, second_nxt;
  logic [15:0]   frac_r, frac_nxt;
  logic          blend_r, blend_nxt;
  logic          pass_r, pass_nxt;
  key_t          prev_r, prev_nxt;
  logic [15:0]   d_r, d_nxt;
  logic signed [31:0] ix_r, ix_nxt;
  logic signed [MB_W-1:0] target_r, target_nxt;
  logic signed [MB_W-1:0] x1_r, x1_nxt, x2_r, x2_nxt;
  logic signed [32:0] y0_r, y0_nxt, y1_r, y1_nxt, y2_r, y2_nxt, y3_r, y3_nxt;
  logic signed [17:0] t_r, t_nxt;
  logic [16:0]   step_r, step_nxt;
  logic [IW-1:0] it_r, it_nxt;
  logic [3:0]    bstep_r, bstep_nxt;
  logic          ymode_r, ymode_nxt;
  logic signed [MA_W-1:0] u2_r, u2_nxt, t2_r, t2_nxt;
  logic signed [MA_W-1:0] w0_r, w0_nxt, w1_r, w1_nxt, w2_r, w2_nxt, w3_r, w3_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [31:0] res_r, res_nxt;
  logic signed [31:0] s1_r, s1_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_value_r, out_value_nxt;
  logic               out_empty_r, out_empty_nxt;

  key_t rd_q;
  key_t wr_key;
  logic tbl_we;
  logic slot_ok;

  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  logic signed [MP_W-1:0] mp_r;
  logic signed [MP_W-1:0] mp_sh16;
  logic signed [MP_W-1:0] mp_sh1;
  logic signed [ACC_W-1:0] pr;
  logic signed [MA_W-1:0] pr20;

  logic signed [17:0] u;
  logic signed [MB_W-1:0] bp0, bp1, bp2, bp3;
  logic signed [MB_W-1:0] xv;
  logic signed [42:0] diff;
  logic [16:0] step_half;
  logic [NW-1:0] n_eff;
  logic [15:0] whole;
  logic [15:0] first;
  logic signed [ACC_W-1:0] mix_sum;

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_sample_value = out_value_r;
  assign out_curve_empty = out_empty_r;

  assign slot_ok = (int'(in_key_slot) < MAX_KEYS);
  assign tbl_we = start && !busy && !in_mode && slot_ok;
  assign wr_key = '{frame: in_key_frame, value: in_key_value, hold: in_key_hold,
                    out_x: in_out_handle_x, out_y: in_out_handle_y,
                    in_x: in_in_handle_x, in_y: in_in_handle_y};

  bkc_table #(.MAX_KEYS(MAX_KEYS), .AW(AW)) u_table (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (AW'(in_key_slot)),
    .wdata   (wr_key),
    .raddr   (idx_r),
    .rdata_r (rd_q)
  );

  bkc_mul u_mul (
    .clk (clk),
    .a   (ma),
    .b   (mb),
    .p_r (mp_r)
  );

  assign mp_sh16 = mp_r >>> 16;
  assign mp_sh1  = mp_r >>> 1;
  assign pr      = mp_sh16[ACC_W-1:0];
  assign pr20    = mp_sh16[MA_W-1:0];
  assign u       = 18'sd65536 - t_r;
  assign whole   = in_sample_position[31:16];
  assign first   = (whole > frame_count_r - 16'd1) ? frame_count_r - 16'd1 : whole;
  assign n_eff   = (int'(key_count_r) > MAX_KEYS) ? NW'(MAX_KEYS) : NW'(key_count_r);
  assign xv      = sat_x(acc_r);
  assign diff    = {xv[MB_W-1], xv} - {target_r[MB_W-1], target_r};
  assign step_half = step_r >> 1;
  assign mix_sum = (acc_r + $signed(mp_r[ACC_W-1:0])) >>> 16;

  always_comb begin
    if (ymode_r) begin
      bp0 = MB_W'(y0_r);
      bp1 = MB_W'(y1_r);
      bp2 = MB_W'(y2_r);
      bp3 = MB_W'(y3_r);
    end else begin
      bp0 = '0;
      bp1 = x1_r;
      bp2 = x2_r;
      bp3 = MB_W'({d_r, 16'h0000});
    end
  end

  // Multiplier operand selection.
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_X1: begin
        ma = MA_W'({1'b0, d_r});
        mb = MB_W'(prev_r.out_x);
      end
      S_X2: begin
        ma = MA_W'({1'b0, d_r});
        mb = MB_W'(ix_r);
      end
      S_BZ: begin
        case (bstep_r)
          4'd0: begin ma = MA_W'(u);    mb = MB_W'(u);   end
          4'd1: begin ma = MA_W'(t_r);  mb = MB_W'(t_r); end
          4'd2: begin ma = u2_r;        mb = MB_W'(u);   end
          4'd3: begin ma = u2_r;        mb = MB_W'(t_r); end
          4'd4: begin ma = MA_W'(u);    mb = MB_W'(t2_r); end
          4'd5: begin ma = t2_r;        mb = MB_W'(t_r); end
          4'd6: begin ma = w0_r;        mb = bp0;        end
          4'd7: begin ma = w1_r;        mb = bp1;        end
          4'd8: begin ma = w2_r;        mb = bp2;        end
          4'd9: begin ma = w3_r;        mb = bp3;        end
          default: begin ma = '0;       mb = '0;         end
        endcase
      end
      S_MIX1: begin
        ma = MA_W'(ONE_Q - {1'b0, frac_r});
        mb = MB_W'(s1_r);
      end
      S_MIX2: begin
        ma = MA_W'({1'b0, frac_r});
        mb = MB_W'(res_r);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    n_nxt = n_r;
    f_nxt = f_r;
    second_nxt = second_r;
    frac_nxt = frac_r;
    blend_nxt = blend_r;
    pass_nxt = pass_r;
    prev_nxt = prev_r;
    d_nxt = d_r;
    ix_nxt = ix_r;
    target_nxt = target_r;
    x1_nxt = x1_r;
    x2_nxt = x2_r;
    y0_nxt = y0_r;
    y1_nxt = y1_r;
    y2_nxt = y2_r;
    y3_nxt = y3_r;
    t_nxt = t_r;
    step_nxt = step_r;
    it_nxt = it_r;
    bstep_nxt = bstep_r;
    ymode_nxt = ymode_r;
    u2_nxt = u2_r;
    t2_nxt = t2_r;
    w0_nxt = w0_r;
    w1_nxt = w1_r;
    w2_nxt = w2_r;
    w3_nxt = w3_r;
    acc_nxt = acc_r;
    res_nxt = res_r;
    s1_nxt = s1_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    out_empty_nxt = out_empty_r;

    case (state_r)
      S_IDLE: begin
        if (start && in_mode) begin
          if (n_eff == '0) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = '0;
            out_empty_nxt = 1'b1;
          end else begin
            n_nxt = n_eff;
            blend_nxt = blend_cfg_r && (frame_count_r != 16'd0);
            f_nxt = (blend_cfg_r && (frame_count_r != 16'd0)) ? first : whole;
            second_nxt = first + 16'd1;
            frac_nxt = in_sample_position[15:0];
            pass_nxt = 1'b0;
            idx_nxt = '0;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (idx_r == '0) begin
          if (f_r <= rd_q.frame || n_r == NW'(1)) begin
            res_nxt = rd_q.value;
            state_nxt = S_FIN;
          end else begin
            prev_nxt = rd_q;
            idx_nxt = idx_r + AW'(1);
            state_nxt = S_RD;
          end
        end else if (f_r >= prev_r.frame && f_r < rd_q.frame) begin
          if (f_r == prev_r.frame || rd_q.hold) begin
            res_nxt = prev_r.value;
            state_nxt = S_FIN;
          end else begin
            d_nxt = rd_q.frame - prev_r.frame;
            target_nxt = MB_W'({f_r - prev_r.frame, 16'h0000});
            ix_nxt = rd_q.in_x;
            y0_nxt = 33'(prev_r.value);
            y1_nxt = 33'(prev_r.value) + 33'(prev_r.out_y);
            y2_nxt = 33'(rd_q.value) + 33'(rd_q.in_y);
            y3_nxt = 33'(rd_q.value);
            state_nxt = S_X1;
          end
        end else if (int'(idx_r) == int'(n_r) - 1) begin
          res_nxt = rd_q.value;
          state_nxt = S_FIN;
        end else begin
          prev_nxt = rd_q;
          idx_nxt = idx_r + AW'(1);
          state_nxt = S_RD;
        end
      end
      S_X1: begin
        state_nxt = S_X2;
      end
      S_X2: begin
        x1_nxt = sat_x(mp_sh1[ACC_W-1:0]);
        state_nxt = S_X3;
      end
      S_X3: begin
        x2_nxt = sat_x(ACC_W'({d_r, 16'h0000}) + mp_sh1[ACC_W-1:0]);
        t_nxt = '0;
        step_nxt = STEP_START;
        it_nxt = '0;
        bstep_nxt = '0;
        ymode_nxt = 1'b0;
        state_nxt = S_BZ;
      end
      S_BZ: begin
        bstep_nxt = bstep_r + 4'd1;
        case (bstep_r)
          4'd1: u2_nxt = pr20;
          4'd2: t2_nxt = pr20;
          4'd3: w0_nxt = pr20;
          4'd4: w1_nxt = pr20 + (pr20 <<< 1);
          4'd5: w2_nxt = pr20 + (pr20 <<< 1);
          4'd6: w3_nxt = pr20;
          4'd7: acc_nxt = pr;
          4'd8: acc_nxt = acc_r + pr;
          4'd9: acc_nxt = acc_r + pr;
          4'd10: acc_nxt = acc_r + pr;
          4'd11: begin
            bstep_nxt = '0;
            if (ymode_r) begin
              res_nxt = sat32(acc_r);
              state_nxt = S_FIN;
            end else if (diff < TOLERANCE && diff > -TOLERANCE) begin
              state_nxt = S_YST;
            end else if (step_half == '0) begin
              state_nxt = S_YST;
            end else begin
              step_nxt = step_half;
              t_nxt = (xv <= target_r) ? t_r + 18'(step_half) : t_r - 18'(step_half);
              it_nxt = it_r + IW'(1);
              if (int'(it_r) + 1 == MAX_ITERATIONS) begin
                state_nxt = S_YST;
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_YST: begin
        if (t_r < 18'sd0) begin
          t_nxt = '0;
        end else if (t_r > 18'sd65536) begin
          t_nxt = 18'sd65536;
        end
        ymode_nxt = 1'b1;
        bstep_nxt = '0;
        state_nxt = S_BZ;
      end
      S_FIN: begin
        if (!blend_r) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          out_empty_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else if (!pass_r) begin
          s1_nxt = res_r;
          pass_nxt = 1'b1;
          f_nxt = second_r;
          idx_nxt = '0;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_MIX1;
        end
      end
      S_MIX1: begin
        state_nxt = S_MIX2;
      end
      S_MIX2: begin
        acc_nxt = mp_r[ACC_W-1:0];
        state_nxt = S_MIX3;
      end
      S_MIX3: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = sat32(mix_sum);
        out_empty_nxt = 1'b0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      key_count_r <= '0;
      frame_count_r <= '0;
      blend_cfg_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_COUNT:   key_count_r <= cfg_wdata[4:0];
          REG_FRAME_COUNT: frame_count_r <= cfg_wdata;
          REG_BLEND:       blend_cfg_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    n_r <= n_nxt;
    f_r <= f_nxt;
    second_r <= second_nxt;
    frac_r <= frac_nxt;
    blend_r <= blend_nxt;
    pass_r <= pass_nxt;
    prev_r <= prev_nxt;
    d_r <= d_nxt;
    ix_r <= ix_nxt;
    target_r <= target_nxt;
    x1_r <= x1_nxt;
    x2_r <= x2_nxt;
    y0_r <= y0_nxt;
    y1_r <= y1_nxt;
    y2_r <= y2_nxt;
    y3_r <= y3_nxt;
    t_r <= t_nxt;
    step_r <= step_nxt;
    it_r <= it_nxt;
    bstep_r <= bstep_nxt;
    ymode_r <= ymode_nxt;
    u2_r <= u2_nxt;
    t2_r <= t2_nxt;
    w0_r <= w0_nxt;
    w1_r <= w1_nxt;
    w2_r <= w2_nxt;
    w3_r <= w3_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    s1_r <= s1_nxt;
    out_value_r <= out_value_nxt;
    out_empty_r <= out_empty_nxt;
  end

endmodule
